/* sv/pts_pkg.sv */
`default_nettype none
package pts_pkg;

    localparam int CNT_W   = 4;
    localparam int WORD_W  = 32;
    localparam int VAL_W   = 33;
    localparam int ACC_W   = 40;
    localparam int OUT_W   = 16;
    localparam int Q_FRAC  = 24;
    localparam int MAG_W   = Q_FRAC + 1;
    localparam int SCALE_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [SCALE_W-1:0] SCALE_FULL = 15'd32767;
    localparam logic [MAG_W-1:0]   ONE_Q24    = 25'h100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_SAMPLE_WIDTH  = 2'd1,
        CFG_FLOAT_SAMPLES = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [WORD_W-1:0] sample_word;
        logic              packet_last;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_sample;
        logic signed [OUT_W-1:0] right_sample;
    } t_out_item;

    // One finished frame handed from front to back.
    typedef struct packed {
        logic                    stereo;
        logic                    flt;
        logic [CNT_W-1:0]        ch;
        logic signed [ACC_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_MUL_L,
        B_MUL_R,
        B_OUT
    } t_bstate;

    // IEEE single to Q.24, magnitude truncated and saturated at 2^31, NaN is zero.
    function automatic logic signed [VAL_W-1:0] float_to_q24(input logic [WORD_W-1:0] w);
        logic [7:0]  e;
        logic [22:0] f;
        logic [30:0] t;
        logic [4:0]  sh;
        logic [31:0] mag;
        e   = w[30:23];
        f   = w[22:0];
        t   = {1'b1, f, 7'b0};
        sh  = 5'(8'd133 - e);
        mag = '0;
        if (e == 8'hFF) begin
            mag = (f != '0) ? 32'h0 : 32'h8000_0000;
        end else if (e == 8'h00) begin
            mag = '0;
        end else if (e >= 8'd134) begin
            mag = 32'h8000_0000;
        end else if (e >= 8'd103) begin
            mag = {1'b0, t >> sh};
        end else begin
            mag = '0;
        end
        return w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Clamp a Q.24 value to [-1,1] and return its magnitude.
    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] m;
        m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
        return (m > ACC_W'(ONE_Q24)) ? ONE_Q24 : m[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* sv/pcm_to_stereo16_downmix_top.sv */
`default_nettype none
// Channel  Direction  Handshake               Beat
// in       sink       i_in_valid/o_in_ready   t_in_item: sample_word, packet_last
// out      source     o_out_valid/i_out_ready t_out_item: left_sample, right_sample
// cfg      sink       i_cfg_valid/o_cfg_ready register index, write data
//
// The front takes one input beat per cycle while the two-entry frame queue has room.
// The back takes one frame at a time: a stereo or one-channel frame goes through B_MUL_L,
// B_MUL_R and B_OUT, and an averaged frame first runs the bit-serial divider (one quotient
// bit per cycle over 40 bits).
// Reset is synchronous, active low; config returns to 2 channels, 16-bit PCM.
// Either side may stall independently; the output register holds a result until taken.
module pcm_to_stereo16_downmix_top #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire pts_pkg::t_in_item                   i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output pts_pkg::t_out_item                       o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic          push;
    pts_pkg::t_job push_job;
    logic          q_full;
    logic          q_valid;
    pts_pkg::t_job q_job;
    logic          pop;

    // config writes must land only while idle; the block does not enforce this: always take them
    assign o_cfg_ready = 1'b1;

    // front: convert each sample, advance the channel position, push whole frames
    pts_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (push_job),
        .i_q_full    (q_full)
    );

    // queue: decouple the sample side from the divide and scale side
    pts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // back: average, clamp and scale float samples, then hold the stereo pair for the sink
    pts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* sv/pts_front.sv */
`default_nettype none
module pts_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire pts_pkg::t_in_item                   i_in_data,
    input  wire logic                                i_cfg_valid,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                     o_push,
    output pts_pkg::t_job                            o_job,
    input  wire logic                                i_q_full
);

    localparam int PW = $clog2(MAX_CHANNELS + 1);
    localparam logic [pts_pkg::CNT_W:0] MAXC = (pts_pkg::CNT_W + 1)'(MAX_CHANNELS);

    logic [pts_pkg::CNT_W-1:0]        r_channel_count;
    logic                             r_sample_width;
    logic                             r_float_samples;
    logic [PW-1:0]                    r_pos, n_pos;
    logic signed [pts_pkg::ACC_W-1:0] r_acc, n_acc;
    logic signed [pts_pkg::VAL_W-1:0] r_held_left, n_held_left;

    logic                             accept;
    logic                             is_float;
    logic [pts_pkg::CNT_W-1:0]        ch_eff;
    logic signed [pts_pkg::VAL_W-1:0] v;
    logic signed [pts_pkg::ACC_W-1:0] sum;
    logic [pts_pkg::CNT_W:0]          pos_inc;
    logic [pts_pkg::WORD_W-1:0]       w;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_float   = r_sample_width && r_float_samples;
    assign w          = i_in_data.sample_word;

    always_comb begin
        if (r_channel_count == '0) begin
            ch_eff = pts_pkg::CNT_W'(1);
        end else if ({1'b0, r_channel_count} > MAXC) begin
            ch_eff = MAXC[pts_pkg::CNT_W-1:0];
        end else begin
            ch_eff = r_channel_count;
        end
    end

    always_comb begin
        if (!r_sample_width) begin
            v = {{17{w[15]}}, w[15:0]};
        end else if (is_float) begin
            v = pts_pkg::float_to_q24(w);
        end else begin
            v = {{17{w[31]}}, w[31:16]};
        end
    end

    assign sum     = r_acc + {{(pts_pkg::ACC_W - pts_pkg::VAL_W){v[pts_pkg::VAL_W-1]}}, v};
    assign pos_inc = (pts_pkg::CNT_W + 1)'(r_pos) + (pts_pkg::CNT_W + 1)'(1);

    always_comb begin
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_held_left = r_held_left;
        o_push      = 1'b0;
        o_job.stereo = 1'b0;
        o_job.flt    = is_float;
        o_job.ch     = ch_eff;
        o_job.a      = sum;
        o_job.b      = v;
        if (accept) begin
            if (ch_eff == pts_pkg::CNT_W'(2)) begin
                o_job.stereo = 1'b1;
                o_job.a = {{(pts_pkg::ACC_W - pts_pkg::VAL_W){r_held_left[pts_pkg::VAL_W-1]}},
                           r_held_left};
                if (r_pos == '0) begin
                    n_held_left = v;
                    n_pos       = PW'(1);
                end else begin
                    o_push = 1'b1;
                    n_pos  = '0;
                end
            end else if (pos_inc >= {1'b0, ch_eff}) begin
                o_push = 1'b1;
                n_pos  = '0;
                n_acc  = '0;
            end else begin
                n_acc = sum;
                n_pos = PW'(pos_inc);
            end
            // packet end: drop any partial frame
            if (i_in_data.packet_last) begin
                n_pos = '0;
                n_acc = '0;
            end
        end
        if (i_cfg_valid) begin
            case (i_cfg_index)
                pts_pkg::CFG_CHANNEL_COUNT,
                pts_pkg::CFG_SAMPLE_WIDTH,
                pts_pkg::CFG_FLOAT_SAMPLES: begin
                    n_pos = '0;
                    n_acc = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= pts_pkg::CNT_W'(2);
            r_sample_width  <= 1'b0;
            r_float_samples <= 1'b0;
            r_pos           <= '0;
            r_acc           <= '0;
        end else begin
            r_pos <= n_pos;
            r_acc <= n_acc;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pts_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                    pts_pkg::CFG_SAMPLE_WIDTH:  r_sample_width  <= i_cfg_data[0];
                    pts_pkg::CFG_FLOAT_SAMPLES: r_float_samples <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_left <= n_held_left;
    end

endmodule
`default_nettype wire

/* sv/pts_queue.sv */
`default_nettype none
module pts_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pts_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    output pts_pkg::t_job      o_job,
    input  wire logic          i_pop
);

    pts_pkg::t_job r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

/* sv/pts_back.sv */
`default_nettype none
module pts_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire pts_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pts_pkg::t_out_item o_out_data
);

    localparam int ACC_W = pts_pkg::ACC_W;
    localparam int CW    = $clog2(ACC_W);
    localparam int PRD_W = pts_pkg::MAG_W + pts_pkg::SCALE_W;

    pts_pkg::t_bstate r_state, n_state;

    logic                          r_stereo;
    logic                          r_flt;
    logic [pts_pkg::CNT_W-1:0]     r_ch;
    logic signed [ACC_W-1:0]       r_a;
    logic signed [pts_pkg::VAL_W-1:0] r_b;
    logic                          r_neg;
    logic [ACC_W-1:0]              r_dvd;
    logic [pts_pkg::CNT_W-1:0]     r_rem;
    logic [CW-1:0]                 r_cnt;
    logic [pts_pkg::SCALE_W-1:0]   r_sc_l, r_sc_r;
    logic                          r_neg_l, r_neg_r;
    logic                          r_o_valid;
    pts_pkg::t_out_item            r_o_data;

    logic                          load;
    logic [pts_pkg::CNT_W:0]       rem_sh;
    logic                          qbit;
    logic [ACC_W-1:0]              q_next;
    logic signed [ACC_W-1:0]       mul_in;
    logic [pts_pkg::MAG_W-1:0]     mag;
    logic [PRD_W-1:0]              prod;
    logic signed [pts_pkg::OUT_W-1:0] left_v, right_v, sc_l_s, sc_r_s;

    assign load = (r_state == pts_pkg::B_OUT) && (!r_o_valid || i_out_ready);

    // next state and queue pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            pts_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (!i_job.stereo && (i_job.ch != pts_pkg::CNT_W'(1))) begin
                        n_state = pts_pkg::B_DIV;
                    end else begin
                        n_state = pts_pkg::B_MUL_L;
                    end
                end
            end
            pts_pkg::B_DIV: begin
                if (r_cnt == '0) begin
                    n_state = pts_pkg::B_MUL_L;
                end
            end
            pts_pkg::B_MUL_L: n_state = pts_pkg::B_MUL_R;
            pts_pkg::B_MUL_R: n_state = pts_pkg::B_OUT;
            pts_pkg::B_OUT: begin
                if (load) begin
                    n_state = pts_pkg::B_IDLE;
                end
            end
            default: n_state = pts_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring divide step, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[ACC_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_ch});
    assign q_next = {r_dvd[ACC_W-2:0], qbit};

    assign mul_in = (r_state == pts_pkg::B_MUL_R) ?
                    {{(ACC_W - pts_pkg::VAL_W){r_b[pts_pkg::VAL_W-1]}}, r_b} : r_a;
    assign mag    = pts_pkg::clamp_mag(mul_in);
    assign prod   = PRD_W'(mag) * PRD_W'(pts_pkg::SCALE_FULL);

    always_ff @(posedge i_clk) begin
        case (r_state)
            pts_pkg::B_IDLE: begin
                r_stereo <= i_job.stereo;
                r_flt    <= i_job.flt;
                r_ch     <= i_job.ch;
                r_a      <= i_job.a;
                r_b      <= i_job.b;
                r_neg    <= i_job.a[ACC_W-1];
                r_dvd    <= i_job.a[ACC_W-1] ? ACC_W'(-i_job.a) : ACC_W'(i_job.a);
                r_rem    <= '0;
                r_cnt    <= CW'(ACC_W - 1);
            end
            pts_pkg::B_DIV: begin
                r_dvd <= q_next;
                r_rem <= qbit ? pts_pkg::CNT_W'(rem_sh - {1'b0, r_ch})
                              : rem_sh[pts_pkg::CNT_W-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_a <= r_neg ? -$signed(q_next) : $signed(q_next);
                end
            end
            pts_pkg::B_MUL_L: begin
                r_sc_l  <= prod[pts_pkg::Q_FRAC +: pts_pkg::SCALE_W];
                r_neg_l <= mul_in[ACC_W-1];
            end
            pts_pkg::B_MUL_R: begin
                r_sc_r  <= prod[pts_pkg::Q_FRAC +: pts_pkg::SCALE_W];
                r_neg_r <= mul_in[ACC_W-1];
            end
            default: ;
        endcase
    end

    assign sc_l_s = r_neg_l ? -$signed({1'b0, r_sc_l}) : $signed({1'b0, r_sc_l});
    assign sc_r_s = r_neg_r ? -$signed({1'b0, r_sc_r}) : $signed({1'b0, r_sc_r});

    always_comb begin
        left_v  = r_flt ? sc_l_s : r_a[pts_pkg::OUT_W-1:0];
        right_v = left_v;
        if (r_stereo) begin
            right_v = r_flt ? sc_r_s : r_b[pts_pkg::OUT_W-1:0];
        end
    end

    // output register: hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_data.left_sample  <= left_v;
            r_o_data.right_sample <= right_v;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule
`default_nettype wire

/* tb/pcm_to_stereo16_downmix_top_tb.sv */
`default_nettype none
module pcm_to_stereo16_downmix_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_CH          = 8;
    localparam int     RANDOM_BEATS    = 400;
    localparam int     SETTLE_CYCLES   = 128;   // covers a divide with both queue slots full
    localparam int     HOLD_CYCLES     = 400;
    localparam int     CYCLE_LIMIT     = 400_000;
    localparam int     MAX_REPORTS     = 40;
    localparam longint UNITY_Q24       = 64'sh0000_0000_0100_0000;
    localparam longint SAT_MAG_Q24     = 64'sh0000_0000_8000_0000;
    localparam longint PCM_FULL        = 32767;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    // Predict the stereo pairs from the accepted sample beats and hold them until they come out.
    class downmix_scoreboard;
        logic [pts_pkg::CNT_W-1:0]        chan_reg;
        logic                             wide_reg;
        logic                             float_reg;
        int unsigned                      slot;
        longint                           frame_sum;
        logic signed [pts_pkg::OUT_W-1:0] left_hold;
        pts_pkg::t_out_item               pairs_due[$];
        int                               errors;

        function new();
            chan_reg  = 4'd2;
            wide_reg  = 1'b0;
            float_reg = 1'b0;
            slot      = 0;
            frame_sum = 0;
            left_hold = '0;
            errors    = 0;
        endfunction

        function void drop_frame();
            slot      = 0;
            frame_sum = 0;
        endfunction

        // Zero channels count as one, anything above the maximum saturates.
        function int frame_len();
            if (chan_reg == '0)
                return 1;
            if (int'(chan_reg) > MAX_CH)
                return MAX_CH;
            return int'(chan_reg);
        endfunction

        // IEEE single to Q.24: truncate the magnitude, saturate at 128, NaN reads as zero.
        function longint float_to_fix(logic [31:0] w);
            int     shift;
            longint mag;
            shift = int'(w[30:23]) - 126;
            if (w[30:23] == 8'hFF)
                mag = (w[22:0] != '0) ? 0 : SAT_MAG_Q24;
            else if (w[30:23] == 8'h00)
                mag = 0;
            else if (shift >= 8)
                mag = SAT_MAG_Q24;
            else if (shift >= 0)
                mag = longint'({1'b1, w[22:0]}) << shift;
            else if (shift <= -24)
                mag = 0;
            else
                mag = longint'({1'b1, w[22:0]}) >> (-shift);
            if (mag > SAT_MAG_Q24)
                mag = SAT_MAG_Q24;
            return w[31] ? -mag : mag;
        endfunction

        // Clamp to [-1,1], scale by full scale and truncate toward zero.
        function logic signed [pts_pkg::OUT_W-1:0] fix_to_pcm(longint q);
            longint c;
            longint mag;
            c = (q > UNITY_Q24) ? UNITY_Q24 : ((q < -UNITY_Q24) ? -UNITY_Q24 : q);
            mag = ((c < 0 ? -c : c) * PCM_FULL) >> 24;
            return (c < 0) ? pts_pkg::OUT_W'(-mag) : pts_pkg::OUT_W'(mag);
        endfunction

        function longint word_value(logic [31:0] w);
            if (!wide_reg)
                return longint'($signed(w[15:0]));
            if (float_reg)
                return float_to_fix(w);
            return longint'($signed(w[31:16]));
        endfunction

        function void set_reg(pts_pkg::t_cfg_index idx,
                              logic [pts_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pts_pkg::CFG_CHANNEL_COUNT: chan_reg  = data;
                pts_pkg::CFG_SAMPLE_WIDTH:  wide_reg  = data[0];
                pts_pkg::CFG_FLOAT_SAMPLES: float_reg = data[0];
                default:                    return;
            endcase
            drop_frame();
        endfunction

        function void note_sample(pts_pkg::t_in_item beat);
            int                               chans;
            logic                             flt;
            longint                           v;
            logic signed [pts_pkg::OUT_W-1:0] m;
            pts_pkg::t_out_item               pair;
            chans = frame_len();
            flt   = wide_reg && float_reg;
            v     = word_value(beat.sample_word);
            if (chans == 2) begin
                m = flt ? fix_to_pcm(v) : pts_pkg::OUT_W'(v);
                if (slot == 0) begin
                    left_hold = m;
                    slot      = 1;
                end else begin
                    pair.left_sample  = left_hold;
                    pair.right_sample = m;
                    pairs_due.insert(pairs_due.size(), pair);
                    drop_frame();
                end
            end else begin
                frame_sum += v;
                slot++;
                if (slot >= chans) begin
                    v = frame_sum / longint'(chans);
                    m = flt ? fix_to_pcm(v) : pts_pkg::OUT_W'(v);
                    pair.left_sample  = m;
                    pair.right_sample = m;
                    pairs_due.insert(pairs_due.size(), pair);
                    drop_frame();
                end
            end
            if (beat.packet_last)
                drop_frame();
        endfunction

        function void check_pair(pts_pkg::t_out_item got);
            pts_pkg::t_out_item want;
            if (pairs_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pair, expected none, got L=%0d R=%0d",
                             $time, got.left_sample, got.right_sample);
                return;
            end
            want = pairs_due[0];
            pairs_due.delete(0);
            if (got.left_sample !== want.left_sample) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: left_sample mismatch, expected %0d, got %0d",
                             $time, want.left_sample, got.left_sample);
            end
            if (got.right_sample !== want.right_sample) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: right_sample mismatch, expected %0d, got %0d",
                             $time, want.right_sample, got.right_sample);
            end
        endfunction

        function int pending();
            return pairs_due.size();
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    pts_pkg::t_in_item              i_in_data   = '0;
    logic                           i_out_ready = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [pts_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pts_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    pts_pkg::t_out_item             o_out_data;
    logic                           o_cfg_ready;

    downmix_scoreboard sb = new();

    t_rx_mode rx_mode       = RX_ALWAYS;
    int       rx_tick       = 0;
    int       hold_left     = 0;
    int       holds_asked   = 0;
    int       holds_granted = 0;
    int       cycle_count   = 0;
    int       burst_left    = 0;
    bit       bursty        = 1'b0;

    pcm_to_stereo16_downmix_top #(
        .MAX_CHANNELS (MAX_CH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Sample all three channels at the edge; the values seen are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(pts_pkg::t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_sample(i_in_data);
            if (o_out_valid && i_out_ready)
                sb.check_pair(o_out_data);
        end
    end

    // Receiver: a long hold-off when asked, otherwise stall on the current pattern.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_granted != holds_asked) begin
            holds_granted <= holds_granted + 1;
            hold_left     <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_out_ready <= 1'b1;
                RX_PATTERN: i_out_ready <= (rx_tick % 7) >= 3;
                RX_RANDOM:  i_out_ready <= $urandom_range(0, 3) != 0;
                default:    i_out_ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs still due", cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Write all three registers back to back; hold valid high across the writes.
    task automatic write_config(input logic [pts_pkg::CNT_W-1:0] chans, input logic wide,
                                input logic flt);
        pts_pkg::t_cfg_index            regs [3] = '{pts_pkg::CFG_CHANNEL_COUNT,
                                                     pts_pkg::CFG_SAMPLE_WIDTH,
                                                     pts_pkg::CFG_FLOAT_SAMPLES};
        logic [pts_pkg::CFG_DATA_W-1:0] vals [3];
        vals[0] = chans;
        // Toggle the unused data bits too; only bit 0 counts for the flags.
        vals[1] = pts_pkg::CFG_DATA_W'({$urandom, wide});
        vals[2] = pts_pkg::CFG_DATA_W'({$urandom, flt});
        for (int r = 0; r < 3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one sample beat and return at the edge that takes it. In bursty mode, gaps come between bursts.
    task automatic send_beat(input logic [pts_pkg::WORD_W-1:0] word, input logic last);
        pts_pkg::t_in_item beat;
        int                gap;
        beat.sample_word = word;
        beat.packet_last = last;
        if (burst_left == 0) begin
            if (bursty) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(1, 4);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every predicted pair has come out.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Drain, then let a dropped partial frame or a divide still in flight finish.
    task automatic quiesce();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [pts_pkg::WORD_W-1:0] pick_word(input logic wide,
                                                             input logic flt);
        logic [pts_pkg::WORD_W-1:0] w;
        logic [15:0]                rail;
        w = $urandom;
        if (wide && flt) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom;
                1:       w = {w[31], 8'hFF, ($urandom_range(0, 1) ? w[22:0] : 23'd0)};
                2:       w = {w[31], 8'h00, w[22:0]};
                default: w = {w[31], 8'($urandom_range(100, 136)), w[22:0]};
            endcase
        end else if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0:       rail = 16'h8000;
                1:       rail = 16'h7FFF;
                2:       rail = 16'h0000;
                default: rail = 16'hFFFF;
            endcase
            if (wide)
                w[31:16] = rail;
            else
                w[15:0] = rail;
        end
        return w;
    endfunction

    initial begin
        int                        phase;
        int                        sent;
        int                        target;
        int                        random_sent;
        int                        flen;
        bit                        broken;
        logic [pts_pkg::CNT_W-1:0] chans;
        logic                      wide;
        logic                      flt;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings are stereo 16-bit PCM.
        send_beat(32'h0000_7FFF, 1'b0);     // full-scale positive left
        send_beat(32'hFFFF_8000, 1'b0);     // full-scale negative right, upper half ignored
        send_beat(32'h5A5A_0000, 1'b0);
        send_beat(32'hA5A5_FFFF, 1'b1);     // packet end on the last channel still emits
        send_beat(32'h0000_1234, 1'b0);     // left only: the next register write drops it
        quiesce();

        // Zero channels behave as mono; 32-bit PCM keeps the top half.
        write_config(4'd0, 1'b1, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b1);
        quiesce();

        // Fifteen channels saturate to eight; float specials in one averaged frame.
        write_config(4'd15, 1'b1, 1'b1);
        send_beat(32'h7F80_0000, 1'b0);     // +inf
        send_beat(32'hFF80_0000, 1'b0);     // -inf
        send_beat(32'hFFFF_FFFF, 1'b0);     // NaN
        send_beat(32'h3F80_0000, 1'b0);     // 1.0
        send_beat(32'hBF00_0000, 1'b0);     // -0.5
        send_beat(32'h0000_0001, 1'b0);     // subnormal
        send_beat(32'h7F7F_FFFF, 1'b0);     // largest finite
        send_beat(32'h3A83_126F, 1'b0);     // about 0.001
        send_beat(32'h3F00_0000, 1'b0);     // packet end inside the frame drops these three
        send_beat(32'hC000_0000, 1'b0);
        send_beat(32'h4000_0000, 1'b1);
        quiesce();

        // Three channels of 16-bit; float flag must be ignored; negative average truncates.
        write_config(4'd3, 1'b0, 1'b1);
        send_beat(32'h0000_8000, 1'b0);
        send_beat(32'hFFFF_8000, 1'b0);
        send_beat(32'h1234_8001, 1'b1);
        quiesce();

        // Stereo float: clamp above one, -0, and the smallest step that survives.
        write_config(4'd2, 1'b1, 1'b1);
        send_beat(32'h3FC0_0000, 1'b0);
        send_beat(32'hBF7F_FFFF, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h3380_0000, 1'b1);
        quiesce();

        // Random phases: mostly whole frames, some cut short by a packet end.
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_BEATS) begin
            phase++;
            case ($urandom_range(0, 11))
                8:       chans = 4'd0;
                9, 10:   chans = 4'($urandom_range(9, 15));
                11:      chans = 4'd8;
                default: chans = 4'($urandom_range(1, 8));
            endcase
            wide = 1'($urandom_range(0, 1));
            flt  = 1'($urandom_range(0, 1));
            write_config(chans, wide, flt);

            bursty = $urandom_range(0, 3) != 0;
            if (phase == 1) begin
                bursty = 1'b0;
                rx_mode <= RX_ALWAYS;
            end else begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            // Hold the receiver off while the sender keeps pushing, so the input stalls.
            if (phase == 2 || phase == 6) begin
                bursty = 1'b0;
                holds_asked <= holds_asked + 1;
            end

            target = $urandom_range(25, 50);
            sent   = 0;
            while (sent < target) begin
                flen   = sb.frame_len();
                broken = 1'b0;
                if (flen > 1 && $urandom_range(0, 11) == 0) begin
                    flen   = $urandom_range(1, flen - 1);
                    broken = 1'b1;
                end
                for (int k = 0; k < flen; k++) begin
                    send_beat(pick_word(wide, flt),
                              (k == flen - 1) && (broken || $urandom_range(0, 3) == 0));
                    sent++;
                end
                // Pause the sender once mid-phase until everything has come out.
                if (phase == 4 && sent >= target / 2 && sent - flen < target / 2)
                    wait_results();
            end
            random_sent += sent;
            quiesce();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

/* pcm_to_stereo16_downmix_top.f */
sv/pts_pkg.sv
sv/pts_front.sv
sv/pts_queue.sv
sv/pts_back.sv
sv/pcm_to_stereo16_downmix_top.sv
tb/pcm_to_stereo16_downmix_top_tb.sv
